// File: sv/iff_pkg.sv
// shared types, character codes and digit tables of the integer field formatter
`default_nettype none

package iff_pkg;

  localparam int MAG_W = 64;

  // radix selector codes
  localparam logic [1:0] OP_DEC    = 2'd0;
  localparam logic [1:0] OP_OCT    = 2'd1;
  localparam logic [1:0] OP_HEX_LO = 2'd2;
  localparam logic [1:0] OP_HEX_UP = 2'd3;

  // ascii codes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_X_UPPER = 8'h58;
  localparam logic [7:0] CH_X_LOWER = 8'h78;

  localparam logic [7:0] DIGITS_UPPER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };
  localparam logic [7:0] DIGITS_LOWER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  // control from the formatter to the digit unit
  typedef struct packed {
    logic load;
    logic pop;
  } dig_cmd_t;

  // status from the digit unit
  typedef struct packed {
    logic ready;
  } dig_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    return upper ? DIGITS_UPPER[d] : DIGITS_LOWER[d];
  endfunction

endpackage

`default_nettype wire

// File: sv/iff_digits.sv
// digit unit: bit-serial binary to bcd, octal and hex split, leading zero strip
`default_nettype none

module iff_digits #(
  parameter int DIGIT_BUF = 22,
  localparam int NW = $clog2(DIGIT_BUF + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire iff_pkg::dig_cmd_t            cmd,
  input  wire logic [iff_pkg::MAG_W-1:0]    magnitude,
  input  wire logic [1:0]                   op,
  output iff_pkg::dig_stat_t                stat,
  output logic [3:0]                        top_digit,
  output logic [NW-1:0]                     ndig
);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_CONV = 4'b0010,
    D_NORM = 4'b0100,
    D_HOLD = 4'b1000
  } dstate_t;

  localparam int BW = $clog2(iff_pkg::MAG_W);

  dstate_t                   state;
  logic [3:0]                dig [DIGIT_BUF];
  logic [iff_pkg::MAG_W-1:0] mag;
  logic [BW-1:0]             bitcnt;

  logic [3:0] adj      [DIGIT_BUF];
  logic [3:0] dd_next  [DIGIT_BUF];
  logic [3:0] shifted  [DIGIT_BUF];
  logic [3:0] load_val [DIGIT_BUF];
  logic       shift_ok;

  assign top_digit  = dig[DIGIT_BUF-1];
  assign shift_ok   = (ndig > NW'(1)) && (top_digit == 4'd0);
  assign stat.ready = (state == D_HOLD);

  always_comb begin
    logic [iff_pkg::MAG_W-1:0] grp;
    for (int i = 0; i < DIGIT_BUF; i++) begin
      adj[i] = (dig[i] >= 4'd5) ? dig[i] + 4'd3 : dig[i];
    end
    for (int i = 0; i < DIGIT_BUF; i++) begin
      if (i == 0) begin
        dd_next[i] = {adj[i][2:0], mag[iff_pkg::MAG_W-1]};
        shifted[i] = 4'd0;
      end else begin
        dd_next[i] = {adj[i][2:0], adj[i-1][3]};
        shifted[i] = dig[i-1];
      end
      if (op == iff_pkg::OP_OCT) begin
        grp = magnitude >> (3 * i);
        load_val[i] = {1'b0, grp[2:0]};
      end else if (op == iff_pkg::OP_DEC) begin
        grp = '0;
        load_val[i] = 4'd0;
      end else begin
        grp = magnitude >> (4 * i);
        load_val[i] = grp[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else if (cmd.load) begin
      state <= (op == iff_pkg::OP_DEC) ? D_CONV : D_NORM;
    end else begin
      unique case (state)
        D_IDLE: state <= D_IDLE;
        D_CONV: if (bitcnt == '0) state <= D_NORM;
        D_NORM: if (!shift_ok) state <= D_HOLD;
        D_HOLD: state <= D_HOLD;
        default: state <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dig    <= load_val;
      mag    <= magnitude;
      bitcnt <= BW'(iff_pkg::MAG_W - 1);
      ndig   <= NW'(DIGIT_BUF);
    end else if (state == D_CONV) begin
      dig    <= dd_next;
      mag    <= mag << 1;
      bitcnt <= bitcnt - BW'(1);
    end else if (state == D_NORM && shift_ok) begin
      dig  <= shifted;
      ndig <= ndig - NW'(1);
    end else if (state == D_HOLD && cmd.pop) begin
      dig <= shifted;
    end
  end

  a_ndig_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == D_HOLD |-> ndig != '0)
    else $error("digit unit holds an empty digit string");

endmodule

`default_nettype wire

// File: sv/integer_field_formatter.sv
// top level of the integer field formatter: printf-style integer text, one character per transfer
//
// input channel s_*: one transfer carries a value and its format; accepted when s_tvalid and
// s_tready are high at a rising edge. s_tready is high only while no item is in progress.
// output channel m_*: one character per transfer, m_tlast on the final character of a field.
// the digit unit loads at the accepting edge; decimal then runs the shift-and-add-3
// conversion, one magnitude bit per cycle; octal and hex digits are loaded directly.
// leading zero digits are then shifted out one per cycle (at most DIGIT_BUF-1 of them), the
// digit unit sees the end and holds, the field layout is set up, and the characters leave at one
// per cycle while the receiver takes them.
// the output register lets the next item be accepted while the final character still waits.
// a stall on m_tready holds the character in the output register and pauses the emitter.
// reset (synchronous, active high) empties the output register and returns to idle.
`default_nettype none

module integer_field_formatter #(
  parameter int MAX_FIELD = 48,
  parameter int DIGIT_BUF = 22
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [63:0] magnitude, [69:64] field_width, [75:70] precision, [76] no_precision, [77] left_justify,
  // [78] zero_fill, [79] force_plus, [80] space_sign, [81] alternate, [87:82] zero
  input  wire logic [87:0] s_tdata,
  // [0] negative, [2:1] op
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] char_out
  output logic [7:0]       m_tdata,
  output logic             m_tlast
);

  localparam int NW = $clog2(DIGIT_BUF + 1);
  localparam int CW = $clog2(MAX_FIELD + DIGIT_BUF + 8);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WAIT = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state;

  // format of the item in progress
  logic          neg, left, zero, plus, space, alt, nonzero, prec_none;
  logic [1:0]    op_r;
  logic [CW-1:0] width_r, prec_r;

  // remaining characters of each segment of the field
  logic [CW-1:0] pad_l, zero_cnt, dig_cnt, pad_r, rem;
  logic          sgn;
  logic [1:0]    alt_cnt;

  iff_pkg::dig_cmd_t  dcmd;
  iff_pkg::dig_stat_t dstat;
  logic [3:0]         top_digit;
  logic [NW-1:0]      ndig;

  logic          accept, emit_step, plan, is_hex, upper;
  logic [CW-1:0] wid_in, prec_in, n_c, used_c, zeros_c, body_c, pad_c, sum_cnt;
  logic [1:0]    alt_c;
  logic [7:0]    ch;
  logic [CW-1:0] pad_l_next, zero_cnt_next, dig_cnt_next, pad_r_next;
  logic          sgn_next, pop;
  logic [1:0]    alt_cnt_next;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign emit_step = (state == S_EMIT) && (!m_tvalid || m_tready);
  assign plan      = (state == S_WAIT) && dstat.ready;
  assign is_hex    = op_r[1];
  assign upper     = (op_r == iff_pkg::OP_HEX_UP);

  assign dcmd.load = accept;
  assign dcmd.pop  = emit_step && pop;

  iff_digits #(.DIGIT_BUF(DIGIT_BUF)) u_digits (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dcmd),
    .magnitude (s_tdata[63:0]),
    .op        (s_tuser[2:1]),
    .stat      (dstat),
    .top_digit (top_digit),
    .ndig      (ndig)
  );

  // width and precision saturate at the field limit
  assign wid_in  = CW'(s_tdata[69:64]);
  assign prec_in = CW'(s_tdata[75:70]);

  // field layout once the digit count is known
  always_comb begin
    n_c = CW'(ndig);
    if (alt && nonzero) begin
      alt_c = is_hex ? 2'd2 : ((op_r == iff_pkg::OP_OCT) ? 2'd1 : 2'd0);
    end else begin
      alt_c = 2'd0;
    end
    used_c = CW'(neg || plus || space) + CW'(alt_c) + n_c;
    if (zero && !left && prec_none) begin
      zeros_c = (width_r > used_c) ? width_r - used_c : '0;
    end else if (!prec_none && prec_r > n_c) begin
      zeros_c = prec_r - n_c;
    end else begin
      zeros_c = '0;
    end
    body_c = used_c + zeros_c;
    pad_c  = (width_r > body_c) ? width_r - body_c : '0;
  end

  // segment order: left pad, sign, prefix, zero fill or precision zeros, digits, right pad
  always_comb begin
    pad_l_next    = pad_l;
    sgn_next      = sgn;
    alt_cnt_next  = alt_cnt;
    zero_cnt_next = zero_cnt;
    dig_cnt_next  = dig_cnt;
    pad_r_next    = pad_r;
    pop           = 1'b0;
    priority if (pad_l != '0) begin
      ch         = iff_pkg::CH_SPACE;
      pad_l_next = pad_l - CW'(1);
    end else if (sgn) begin
      ch       = neg ? iff_pkg::CH_MINUS : (plus ? iff_pkg::CH_PLUS : iff_pkg::CH_SPACE);
      sgn_next = 1'b0;
    end else if (alt_cnt != 2'd0) begin
      if (alt_cnt == 2'd1 && is_hex) begin
        ch = upper ? iff_pkg::CH_X_UPPER : iff_pkg::CH_X_LOWER;
      end else begin
        ch = iff_pkg::CH_ZERO;
      end
      alt_cnt_next = alt_cnt - 2'd1;
    end else if (zero_cnt != '0) begin
      ch            = iff_pkg::CH_ZERO;
      zero_cnt_next = zero_cnt - CW'(1);
    end else if (dig_cnt != '0) begin
      ch           = iff_pkg::digit_char(top_digit, upper);
      dig_cnt_next = dig_cnt - CW'(1);
      pop          = 1'b1;
    end else begin
      ch         = iff_pkg::CH_SPACE;
      pad_r_next = pad_r - CW'(1);
    end
  end

  assign sum_cnt = pad_l + CW'(sgn) + CW'(alt_cnt) + zero_cnt + dig_cnt + pad_r;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (accept) state <= S_WAIT;
        S_WAIT: if (plan) state <= S_EMIT;
        S_EMIT: if (emit_step && rem == CW'(1)) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (emit_step) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // format capture, layout and output data
  always_ff @(posedge clk) begin
    if (accept) begin
      neg       <= s_tuser[0];
      op_r      <= s_tuser[2:1];
      width_r   <= (wid_in > CW'(MAX_FIELD)) ? CW'(MAX_FIELD) : wid_in;
      prec_r    <= (prec_in > CW'(MAX_FIELD)) ? CW'(MAX_FIELD) : prec_in;
      prec_none <= s_tdata[76];
      left      <= s_tdata[77];
      zero      <= s_tdata[78];
      plus      <= s_tdata[79];
      space     <= s_tdata[80];
      alt       <= s_tdata[81];
      nonzero   <= (s_tdata[63:0] != '0);
    end
    if (plan) begin
      pad_l    <= left ? '0 : pad_c;
      pad_r    <= left ? pad_c : '0;
      sgn      <= neg || plus || space;
      alt_cnt  <= alt_c;
      zero_cnt <= zeros_c;
      dig_cnt  <= n_c;
      rem      <= body_c + pad_c;
    end else if (emit_step) begin
      pad_l    <= pad_l_next;
      sgn      <= sgn_next;
      alt_cnt  <= alt_cnt_next;
      zero_cnt <= zero_cnt_next;
      dig_cnt  <= dig_cnt_next;
      pad_r    <= pad_r_next;
      rem      <= rem - CW'(1);
    end
    if (emit_step) begin
      m_tdata <= ch;
      m_tlast <= (rem == CW'(1));
    end
  end

  a_rem_matches: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> rem == sum_cnt)
    else $error("remaining count disagrees with segment counters");

  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> rem != '0)
    else $error("emitter active with no character left");

  a_digits_ready: assert property (@(posedge clk) disable iff (rst)
    dcmd.pop |-> dstat.ready)
    else $error("digit taken before the digit unit finished");

endmodule

`default_nettype wire
